// ----- hw/rtl/screen_space_contact_occlusion_defines.svh -----
// Assertion macros for the contact occlusion block.
`ifndef SCREEN_SPACE_CONTACT_OCCLUSION_DEFINES_SVH
`define SCREEN_SPACE_CONTACT_OCCLUSION_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SSCO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SSCO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ssco_pkg.sv -----
// Shared types, constants and offset tables for the contact occlusion block.
`timescale 1ns / 1ps
`default_nettype none

package ssco_pkg;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RANGE_LIMIT  = 2'd2;

  localparam int          NBR_COUNT   = 12;
  localparam logic [15:0] RANGE_FLOOR = 16'd13;
  localparam logic [14:0] ONE_Q14     = 15'd16384;
  localparam logic [14:0] HSAT_MUL    = 15'd16385;
  localparam logic [14:0] HEMI_MIN    = 15'd163;
  localparam logic [14:0] BASE_Q14    = 15'd11469;
  localparam logic [14:0] SLOPE_Q14   = 15'd4915;
  localparam logic [14:0] SAME_Q14    = 15'd9830;
  localparam logic [12:0] SCALE_Q13   = 13'd5734;
  localparam logic [14:0] CAP_Q15     = 15'd21299;
  localparam logic [15:0] VIS_ONE     = 16'd32768;
  localparam logic signed [37:0] DOT_NN_MAX = 38'sd268435456;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic        go;
    arith_op_t   op;
    logic [47:0] num;
    logic [23:0] den;
  } arith_cmd_t;

  typedef struct packed {
    logic        done;
    logic [23:0] value;
  } arith_rsp_t;

  function automatic logic signed [3:0] nbr_dx(input logic [3:0] k);
    logic signed [3:0] r;
    unique case (k)
      4'd0:    r = -4'sd1;
      4'd1:    r = 4'sd1;
      4'd4:    r = -4'sd2;
      4'd5:    r = 4'sd2;
      4'd6:    r = -4'sd2;
      4'd7:    r = 4'sd2;
      4'd8:    r = -4'sd4;
      4'd9:    r = 4'sd4;
      default: r = 4'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [3:0] nbr_dy(input logic [3:0] k);
    logic signed [3:0] r;
    unique case (k)
      4'd2:    r = -4'sd1;
      4'd3:    r = 4'sd1;
      4'd4:    r = -4'sd2;
      4'd5:    r = -4'sd2;
      4'd6:    r = 4'sd2;
      4'd7:    r = 4'sd2;
      4'd10:   r = -4'sd4;
      4'd11:   r = 4'sd4;
      default: r = 4'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ssco_arith.sv -----
// Iterative unit: bit-serial square root and restoring division.
`timescale 1ns / 1ps
`default_nettype none

module ssco_arith import ssco_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire arith_cmd_t cmd,
  output arith_rsp_t      rsp
);

  logic        running;
  logic        fin;
  arith_op_t   op;
  logic [4:0]  cnt;
  logic [47:0] v;
  logic [47:0] r;
  logic [47:0] b;
  logic [47:0] rb;

  assign rb = r + b;
  assign rsp.done  = fin;
  assign rsp.value = r[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (cmd.go) begin
        running <= 1'b1;
        op      <= cmd.op;
        v       <= cmd.num;
        r       <= '0;
        if (cmd.op == OP_SQRT) begin
          b   <= 48'h1 << 46;
          cnt <= 5'd23;
        end else begin
          b   <= {10'b0, cmd.den, 14'b0};
          cnt <= 5'd14;
        end
      end else if (running) begin
        unique case (op)
          OP_SQRT: begin
            if (v >= rb) begin
              v <= v - rb;
              r <= (r >> 1) + b;
            end else begin
              r <= r >> 1;
            end
            b <= b >> 2;
          end
          OP_DIV: begin
            if (v >= b) begin
              v <= v - b;
              r <= {r[46:0], 1'b1};
            end else begin
              r <= {r[46:0], 1'b0};
            end
            b <= b >> 1;
          end
        endcase
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/screen_space_contact_occlusion.sv -----
// Top level: geometry frame memories and the occlusion gather sequencer.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+------------------
//  item in   | mode pixel_x pixel_y pixel_valid position_*   | start & !busy
//            | normal_* entity_id                            |
//  result    | visibility                                    | done, one cycle
//  config    | cfg_index cfg_data                            | cfg_write
//
// A load writes the memories and busy stays low. A query outside the frame is
// answered without raising busy; otherwise each neighbor may use the 24-step
// square root and up to two 15-step divisions of the shared iterative unit.
// Reset idles the sequencer and clears done; the frame memories stay undefined
// until loaded. The receiver cannot stall: done pulses once per query.
`timescale 1ns / 1ps
`default_nettype none

module screen_space_contact_occlusion import ssco_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic [5:0]         pixel_x,
  input  wire logic [5:0]         pixel_y,
  input  wire logic               pixel_valid,
  input  wire logic signed [15:0] position_x,
  input  wire logic signed [15:0] position_y,
  input  wire logic signed [15:0] position_z,
  input  wire logic signed [15:0] normal_x,
  input  wire logic signed [15:0] normal_y,
  input  wire logic signed [15:0] normal_z,
  input  wire logic [15:0]        entity_id,
  output logic                    done,
  output logic [15:0]             visibility,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WLIM  = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
  localparam int HLIM  = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;

  typedef enum logic [4:0] {
    S_IDLE, S_CLAT, S_NADDR, S_NLAT, S_MUL, S_CHECK, S_SQRT, S_HSAT, S_HDIV,
    S_HCHK, S_RDIV, S_W, S_F, S_T1, S_T2, S_T3, S_NEXT, S_FIN
  } state_t;

  function automatic logic [AW-1:0] pix_addr(input logic [5:0] x, input logic [5:0] y);
    return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
  endfunction

  // frame memories
  logic [47:0] pos_mem [DEPTH];
  logic [47:0] nrm_mem [DEPTH];
  logic [16:0] tag_mem [DEPTH];
  logic [47:0] pos_q;
  logic [47:0] nrm_q;
  logic [16:0] tag_q;
  logic          we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // configuration
  logic [6:0]  frame_w;
  logic [6:0]  frame_h;
  logic [15:0] range_lim;

  // sequencer
  state_t             state;
  logic [5:0]         cx;
  logic [5:0]         cy;
  logic [3:0]         k;
  logic [3:0]         step;
  logic [47:0]        pc;
  logic [47:0]        nc;
  logic [16:0]        tc;
  logic signed [16:0] dlt [3];
  logic signed [33:0] prod;
  logic [1:0]         pgrp;
  logic signed [37:0] acc_d2;
  logic signed [37:0] acc_nd;
  logic signed [37:0] acc_nn;
  logic [23:0]        span;
  logic [14:0]        hq;
  logic [14:0]        rem_r;
  logic [14:0]        wq;
  logic [14:0]        fq;
  logic [14:0]        tq;
  logic [17:0]        occ;

  // combinational
  logic [6:0]         eff_w;
  logic [6:0]         eff_h;
  logic [15:0]        rl;
  logic [31:0]        rl2;
  logic               in_frame;
  logic               in_bounds;
  logic signed [3:0]  dx;
  logic signed [3:0]  dy;
  logic signed [7:0]  sx;
  logic signed [7:0]  sy;
  logic               nbr_out;
  logic [1:0]         grp;
  logic [1:0]         ci;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic               skip;
  logic [47:0]        hnum;
  logic [38:0]        hlim;
  logic               hsat;
  logic [28:0]        nn_c;
  logic [14:0]        nd;
  logic [14:0]        ent_w;
  logic [14:0]        mx;
  logic [14:0]        my;
  logic [29:0]        mprod;
  logic [30:0]        scaled;
  logic [17:0]        s_raw;
  logic [14:0]        s_cap;
  arith_cmd_t         acmd;
  arith_rsp_t         arsp;

  ssco_arith u_arith (
    .clk (clk),
    .rst (rst),
    .cmd (acmd),
    .rsp (arsp)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    eff_w = (frame_w == 7'd0) ? 7'd1 : ((frame_w > 7'(WLIM)) ? 7'(WLIM) : frame_w);
    eff_h = (frame_h == 7'd0) ? 7'd1 : ((frame_h > 7'(HLIM)) ? 7'(HLIM) : frame_h);
    rl    = (range_lim < RANGE_FLOOR) ? RANGE_FLOOR : range_lim;
    rl2   = 32'(rl) * 32'(rl);

    in_frame  = ({1'b0, pixel_x} < eff_w) && ({1'b0, pixel_y} < eff_h);
    in_bounds = (int'(pixel_x) < MAX_WIDTH) && (int'(pixel_y) < MAX_HEIGHT);

    dx = nbr_dx(k);
    dy = nbr_dy(k);
    sx = $signed({2'b00, cx}) + $signed({{4{dx[3]}}, dx});
    sy = $signed({2'b00, cy}) + $signed({{4{dy[3]}}, dy});
    nbr_out = (sx < 0) || (sy < 0) || (sx >= $signed({1'b0, eff_w}))
           || (sy >= $signed({1'b0, eff_h}));

    we    = (state == S_IDLE) && start && (mode == MODE_LOAD) && in_bounds;
    rd_en = ((state == S_IDLE) && start && (mode == MODE_QUERY) && in_frame)
         || ((state == S_NADDR) && !nbr_out);
    rd_addr = (state == S_IDLE) ? pix_addr(pixel_x, pixel_y) : pix_addr(sx[5:0], sy[5:0]);

    // dot-product operand select: squares, then n.d, then n.n
    grp = 2'd0;
    ci  = 2'd0;
    if (step < 4'd3) begin
      grp = 2'd0;
      ci  = step[1:0];
    end else if (step < 4'd6) begin
      grp = 2'd1;
      ci  = 2'(step - 4'd3);
    end else if (step < 4'd9) begin
      grp = 2'd2;
      ci  = 2'(step - 4'd6);
    end
    mul_a = (grp == 2'd0) ? dlt[ci] : $signed({nc[16*ci+15], nc[16*ci +: 16]});
    mul_b = (grp == 2'd2) ? $signed({nrm_q[16*ci+15], nrm_q[16*ci +: 16]}) : dlt[ci];

    skip = (acc_d2 == 38'sd0) || (acc_d2 >= $signed({6'b0, rl2})) || (acc_nd <= 38'sd0);
    hnum = {4'b0, acc_nd[35:0], 8'b0};
    hlim = 39'(span) * 39'(HSAT_MUL);
    hsat = (hnum >= {9'b0, hlim});

    if (acc_nn < 38'sd0) begin
      nn_c = '0;
    end else if (acc_nn > DOT_NN_MAX) begin
      nn_c = 29'h1000_0000;
    end else begin
      nn_c = acc_nn[28:0];
    end
    nd    = ONE_Q14 - nn_c[28:14];
    ent_w = (tag_q[15:0] == tc[15:0]) ? SAME_Q14 : ONE_Q14;

    // shared Q14 multiplier for the weight chain
    unique case (state)
      S_W:     begin mx = rem_r; my = rem_r;     end
      S_F:     begin mx = nd;    my = SLOPE_Q14; end
      S_T1:    begin mx = wq;    my = hq;        end
      S_T2:    begin mx = tq;    my = fq;        end
      S_T3:    begin mx = tq;    my = ent_w;     end
      default: begin mx = '0;    my = '0;        end
    endcase
    mprod = 30'(mx) * 30'(my);

    scaled = 31'(occ) * 31'(SCALE_Q13);
    s_raw  = scaled[30:13];
    s_cap  = (s_raw > 18'(CAP_Q15)) ? CAP_Q15 : s_raw[14:0];

    acmd = '{go: 1'b0, op: OP_DIV, num: '0, den: '0};
    unique case (state)
      S_CHECK: if (!skip) acmd = '{go: 1'b1, op: OP_SQRT, num: {acc_d2[31:0], 16'b0}, den: '0};
      S_HSAT:  if (!hsat) acmd = '{go: 1'b1, op: OP_DIV, num: hnum, den: span};
      S_HCHK:  if (hq > HEMI_MIN) begin
        acmd = '{go: 1'b1, op: OP_DIV, num: {18'b0, span, 6'b0}, den: {8'b0, rl}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[pix_addr(pixel_x, pixel_y)] <= {position_z, position_y, position_x};
      nrm_mem[pix_addr(pixel_x, pixel_y)] <= {normal_z, normal_y, normal_x};
      tag_mem[pix_addr(pixel_x, pixel_y)] <= {pixel_valid, entity_id};
    end
    if (rd_en) begin
      pos_q <= pos_mem[rd_addr];
      nrm_q <= nrm_mem[rd_addr];
      tag_q <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      frame_w   <= 7'd64;
      frame_h   <= 7'd64;
      range_lim <= 16'd256;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_w   <= cfg_data[6:0];
          CFG_FRAME_HEIGHT: frame_h   <= cfg_data[6:0];
          CFG_RANGE_LIMIT:  range_lim <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start && (mode == MODE_QUERY)) begin
            if (in_frame) begin
              cx    <= pixel_x;
              cy    <= pixel_y;
              state <= S_CLAT;
            end else begin
              visibility <= VIS_ONE;
              done       <= 1'b1;
            end
          end
        end
        S_CLAT: begin
          pc <= pos_q;
          nc <= nrm_q;
          tc <= tag_q;
          if (!tag_q[16]) begin
            visibility <= VIS_ONE;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            k     <= 4'd0;
            occ   <= '0;
            state <= S_NADDR;
          end
        end
        S_NADDR: state <= nbr_out ? S_NEXT : S_NLAT;
        S_NLAT: begin
          if (!tag_q[16]) begin
            state <= S_NEXT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              dlt[i] <= $signed({pos_q[16*i+15], pos_q[16*i +: 16]})
                      - $signed({pc[16*i+15], pc[16*i +: 16]});
            end
            acc_d2 <= '0;
            acc_nd <= '0;
            acc_nn <= '0;
            step   <= 4'd0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          // issue one product per cycle, accumulate the previous one
          if (step != 4'd9) begin
            prod <= mul_a * mul_b;
            pgrp <= grp;
            step <= step + 4'd1;
          end else begin
            state <= S_CHECK;
          end
          if (step != 4'd0) begin
            unique case (pgrp)
              2'd0:    acc_d2 <= acc_d2 + {{4{prod[33]}}, prod};
              2'd1:    acc_nd <= acc_nd + {{4{prod[33]}}, prod};
              default: acc_nn <= acc_nn + {{4{prod[33]}}, prod};
            endcase
          end
        end
        S_CHECK: state <= skip ? S_NEXT : S_SQRT;
        S_SQRT: begin
          if (arsp.done) begin
            span  <= arsp.value;
            state <= S_HSAT;
          end
        end
        S_HSAT: begin
          if (hsat) begin
            hq    <= ONE_Q14;
            state <= S_HCHK;
          end else begin
            state <= S_HDIV;
          end
        end
        S_HDIV: begin
          if (arsp.done) begin
            hq    <= arsp.value[14:0];
            state <= S_HCHK;
          end
        end
        S_HCHK: state <= (hq > HEMI_MIN) ? S_RDIV : S_NEXT;
        S_RDIV: begin
          if (arsp.done) begin
            rem_r <= ONE_Q14 - arsp.value[14:0];
            state <= S_W;
          end
        end
        S_W: begin
          wq    <= mprod[28:14];
          state <= S_F;
        end
        S_F: begin
          fq    <= BASE_Q14 + mprod[28:14];
          state <= S_T1;
        end
        S_T1: begin
          tq    <= mprod[28:14];
          state <= S_T2;
        end
        S_T2: begin
          tq    <= mprod[28:14];
          state <= S_T3;
        end
        S_T3: begin
          occ   <= occ + 18'(mprod[28:14]);
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (k == 4'(NBR_COUNT - 1)) begin
            state <= S_FIN;
          end else begin
            k     <= k + 4'd1;
            state <= S_NADDR;
          end
        end
        S_FIN: begin
          visibility <= VIS_ONE - {1'b0, s_cap};
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "screen_space_contact_occlusion_defines.svh"

  `SSCO_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a query is in progress")
  `SSCO_ASSERT_NOW(a_vis_range, done, (visibility >= 16'd11469) && (visibility <= VIS_ONE), "visibility out of range")
  `SSCO_ASSERT_NEXT(a_load_silent, start && !busy && (mode == MODE_LOAD), !done && !busy, "load transaction produced a result")
  `SSCO_ASSERT_NEXT(a_query_moves, start && !busy && (mode == MODE_QUERY), busy || done, "query transaction dropped")

endmodule

`default_nettype wire
